@@ rtl/core/sbdg_pkg.sv @@
// ----------------------------------------------------------------------------
// Shift button debounce package
// Field widths, codes and defaults shared by the hold-to-shift qualifier.
// ----------------------------------------------------------------------------
package sbdg_pkg;

   localparam int ACTION_W      = 2;
   localparam int BUTTON_ID_W   = 4;
   localparam int BUTTON_IDS    = 2 ** BUTTON_ID_W;
   localparam int EFFECT_W      = 2;
   localparam int STATUS_W      = 2;
   localparam int TIME_W        = 32;
   localparam int MS_W          = 16;
   localparam int CSR_INDEX_W   = 2;

   localparam int NUM_BUTTONS_DEFAULT = 16;

   localparam logic [MS_W-1:0] DEBOUNCE_RESET = MS_W'(250);
   localparam logic [MS_W-1:0] GRACE_RESET    = MS_W'(30);

   typedef enum logic [ACTION_W-1:0] {
      ACTION_PRESS   = 2'd0,
      ACTION_RELEASE = 2'd1,
      ACTION_TICK    = 2'd2
   } action_type;

   typedef enum logic [EFFECT_W-1:0] {
      EFFECT_NONE = 2'd0,
      EFFECT_PUSH = 2'd1,
      EFFECT_POP  = 2'd2
   } effect_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NOT_PRESS       = 2'd0,
      STATUS_GRACE_CANCELLED = 2'd1,
      STATUS_DEBOUNCED       = 2'd2,
      STATUS_TAKEN           = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_MS      = 2'd0,
      CSR_RELEASE_GRACE_MS = 2'd1
   } csr_index_type;

endpackage

@@ rtl/core/shift_button_debounce_grace.sv @@
// ----------------------------------------------------------------------------
// Hold-to-shift button qualifier
// Turns press, release and millisecond-tick beats into push and pop requests
// for a temporary mode, with per-button debounce and a release grace period.
//
//   channel | direction | beat contents
//   --------+-----------+-----------------------------------------------------
//   req_    | in        | action, button_id, mode_is_target
//   rsp_    | out       | effect, reeval_button, press_status, is_active,
//           |           | grace_pending
//   csr_    | in        | index, write data (debounce_ms, release_grace_ms)
//
// Each beat is held in the input register and evaluated on its way into the
// result register, so one beat is accepted per cycle while results are taken;
// rsp_valid rises as the beat enters the result register, and the registered
// read of the last-edge time RAM is issued at acceptance so that it lines up
// with the input register. A result that is not taken holds the input stage,
// and req_ready drops only while both stages are full. Reset is synchronous
// and needs no clearing pass; the RAM is guarded by the per-button seen bits.
// ----------------------------------------------------------------------------
module shift_button_debounce_grace #(
   parameter int NUM_BUTTONS = sbdg_pkg::NUM_BUTTONS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sbdg_pkg::ACTION_W-1:0]   req_action,
   input  logic [sbdg_pkg::BUTTON_ID_W-1:0] req_button_id,
   input  logic                            req_mode_is_target,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sbdg_pkg::EFFECT_W-1:0]   rsp_effect,
   output logic [sbdg_pkg::BUTTON_ID_W-1:0] rsp_reeval_button,
   output logic [sbdg_pkg::STATUS_W-1:0]   rsp_press_status,
   output logic                            rsp_is_active,
   output logic                            rsp_grace_pending,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sbdg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sbdg_pkg::MS_W-1:0]       csr_wdata
);

   import sbdg_pkg::*;

   localparam int SLOT_W = $clog2(NUM_BUTTONS);

   logic [SLOT_W-1:0] slot_lut [BUTTON_IDS];

   for (genvar i = 0; i < BUTTON_IDS; i++) begin : g_slot
      localparam int SLOT_VAL = i % NUM_BUTTONS;
      assign slot_lut[i] = SLOT_W'(SLOT_VAL);
   end

   logic [MS_W-1:0]        debounce_ff;
   logic [MS_W-1:0]        grace_cfg_ff;

   logic                   s1_valid_ff;
   logic [ACTION_W-1:0]    s1_action_ff;
   logic [BUTTON_ID_W-1:0] s1_button_ff;
   logic [SLOT_W-1:0]      s1_slot_ff;
   logic                   s1_target_ff;

   logic [TIME_W-1:0]      now_ms_ff;
   logic [TIME_W-1:0]      now_ms_in;
   logic [NUM_BUTTONS-1:0] seen_ff;
   logic [NUM_BUTTONS-1:0] seen_in;
   logic                   active_ff;
   logic                   active_in;
   logic [MS_W-1:0]        grace_left_ff;
   logic [MS_W-1:0]        grace_left_in;
   logic [BUTTON_ID_W-1:0] grace_button_ff;
   logic [BUTTON_ID_W-1:0] grace_button_in;

   logic                   fwd_ff;
   logic                   fwd_in;
   logic [TIME_W-1:0]      fwd_time_ff;

   logic                   rsp_valid_ff;
   logic [EFFECT_W-1:0]    rsp_effect_ff;
   logic [EFFECT_W-1:0]    rsp_effect_in;
   logic [BUTTON_ID_W-1:0] rsp_reeval_ff;
   logic [BUTTON_ID_W-1:0] rsp_reeval_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [STATUS_W-1:0]    rsp_status_in;
   logic                   rsp_active_ff;
   logic                   rsp_pending_ff;

   logic                   advance;
   logic                   req_fire;
   logic                   stamp;
   logic [SLOT_W-1:0]      ram_raddr;
   logic [TIME_W-1:0]      ram_rdata;
   logic [TIME_W-1:0]      last_time;
   logic [TIME_W-1:0]      elapsed;
   logic                   bounced;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign ram_raddr = req_fire ? slot_lut[req_button_id] : s1_slot_ff;
   assign fwd_in    = stamp && (s1_slot_ff == ram_raddr);
   assign last_time = fwd_ff ? fwd_time_ff : ram_rdata;
   assign elapsed   = now_ms_ff - last_time;
   assign bounced   = seen_ff[s1_slot_ff] && (elapsed < TIME_W'(debounce_ff));

   sbdg_ram #(
      .WIDTH (TIME_W),
      .DEPTH (NUM_BUTTONS)
   ) u_edge_time (
      .clock (clock),
      .we    (stamp),
      .waddr (s1_slot_ff),
      .wdata (now_ms_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      now_ms_in       = now_ms_ff;
      seen_in         = seen_ff;
      active_in       = active_ff;
      grace_left_in   = grace_left_ff;
      grace_button_in = grace_button_ff;
      rsp_effect_in   = EFFECT_NONE;
      rsp_reeval_in   = '0;
      rsp_status_in   = STATUS_NOT_PRESS;
      stamp           = 1'b0;
      if (advance) begin
         case (s1_action_ff)
            ACTION_PRESS: begin
               if (grace_left_ff != '0) begin
                  grace_left_in = '0;
                  stamp         = 1'b1;
                  rsp_status_in = STATUS_GRACE_CANCELLED;
               end else if (bounced) begin
                  rsp_status_in = STATUS_DEBOUNCED;
               end else begin
                  stamp         = 1'b1;
                  rsp_status_in = STATUS_TAKEN;
                  if (!active_ff && !s1_target_ff) begin
                     active_in     = 1'b1;
                     rsp_effect_in = EFFECT_PUSH;
                     rsp_reeval_in = s1_button_ff;
                  end
               end
            end
            ACTION_RELEASE: begin
               stamp = 1'b1;
               if (active_ff) begin
                  grace_left_in   = (grace_cfg_ff != '0) ? grace_cfg_ff : MS_W'(1);
                  grace_button_in = s1_button_ff;
               end
            end
            ACTION_TICK: begin
               now_ms_in = now_ms_ff + TIME_W'(1);
               if (grace_left_ff != '0) begin
                  grace_left_in = grace_left_ff - MS_W'(1);
                  if (grace_left_ff == MS_W'(1)) begin
                     active_in     = 1'b0;
                     rsp_effect_in = EFFECT_POP;
                     rsp_reeval_in = grace_button_ff;
                  end
               end
            end
            default: begin
            end
         endcase
         if (stamp) begin
            seen_in[s1_slot_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         grace_cfg_ff <= GRACE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_MS:      debounce_ff  <= csr_wdata;
            CSR_RELEASE_GRACE_MS: grace_cfg_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         now_ms_ff       <= '0;
         seen_ff         <= '0;
         active_ff       <= 1'b0;
         grace_left_ff   <= '0;
         grace_button_ff <= '0;
         fwd_ff          <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         now_ms_ff       <= now_ms_in;
         seen_ff         <= seen_in;
         active_ff       <= active_in;
         grace_left_ff   <= grace_left_in;
         grace_button_ff <= grace_button_in;
         fwd_ff          <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_time_ff <= now_ms_ff;
      if (req_fire) begin
         s1_action_ff <= req_action;
         s1_button_ff <= req_button_id;
         s1_slot_ff   <= slot_lut[req_button_id];
         s1_target_ff <= req_mode_is_target;
      end
      if (advance) begin
         rsp_effect_ff  <= rsp_effect_in;
         rsp_reeval_ff  <= rsp_reeval_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_active_ff  <= active_in;
         rsp_pending_ff <= (grace_left_in != '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_effect        = rsp_effect_ff;
   assign rsp_reeval_button = rsp_reeval_ff;
   assign rsp_press_status  = rsp_status_ff;
   assign rsp_is_active     = rsp_active_ff;
   assign rsp_grace_pending = rsp_pending_ff;

   a_push_sets_active : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_effect_ff == EFFECT_PUSH) |-> rsp_active_ff)
      else $error("push beat does not report the mode as held");

   a_pop_clears_all : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_effect_ff == EFFECT_POP) |-> !rsp_active_ff && !rsp_pending_ff)
      else $error("pop beat leaves the mode held or a grace pending");

   a_grace_needs_active : assert property (@(posedge clock) disable iff (reset)
      (grace_left_ff != '0) |-> active_ff)
      else $error("grace countdown runs while the mode is not held");

   a_idle_effect_no_button : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_effect_ff == EFFECT_NONE) |-> (rsp_reeval_ff == '0))
      else $error("re-evaluation button set without an effect");

   a_tick_advances_time : assert property (@(posedge clock) disable iff (reset)
      advance && (s1_action_ff == ACTION_TICK) |=> (now_ms_ff == $past(now_ms_ff) + TIME_W'(1)))
      else $error("tick beat did not advance the millisecond count");

endmodule

@@ rtl/core/sbdg_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sbdg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
